### design/bs3_pkg.sv
// Shared constants, types and arithmetic helpers for the 3x3 edge-aware box smoother.
package bs3_pkg;

    localparam int MAX_SIDE   = 2048;
    localparam int COL_W      = $clog2(MAX_SIDE);
    localparam int SIDE_W     = COL_W + 1;
    localparam int ADDR_W     = 3;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    localparam logic [SIDE_W-1:0] SIDE_MIN = SIDE_W'(2);
    localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SIDE);
    localparam logic [11:0]       SIDE_RESET = 12'd2048;

    // Register indexes, taken from paddr[2].
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // Reciprocals for exact division of sum*256 by 3, 6 and 9 (sum below 4096).
    localparam logic [20:0] RECIP_3_6 = 21'd1398102;
    localparam logic [20:0] RECIP_9   = 21'd1864136;

    typedef enum logic [2:0] {
        CNT2,
        CNT3,
        CNT4,
        CNT6,
        CNT9
    } cnt_t;

    typedef struct packed {
        logic [15:0]      smoothed;
        logic [COL_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             frame_end;
        logic             last;
    } result_t;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [11:0] v);
        logic [SIDE_W-1:0] r;
        if (v < SIDE_MIN) r = SIDE_MIN;
        else if (v > SIDE_MAX) r = SIDE_MAX;
        else r = v;
        return r;
    endfunction

    // Number of neighbours from the valid row count and the column span.
    function automatic cnt_t count_code(input logic top_ok, input logic bot_ok,
                                        input logic three_cols);
        cnt_t c;
        if (top_ok && bot_ok) c = three_cols ? CNT9 : CNT6;
        else if (top_ok || bot_ok) c = three_cols ? CNT6 : CNT4;
        else c = three_cols ? CNT3 : CNT2;
        return c;
    endfunction

    // floor(sum*256/count), truncated to 16 bits.
    function automatic logic [15:0] mean_q88(input logic [11:0] sum, input cnt_t cnt);
        logic [20:0] recip;
        logic [32:0] prod;
        logic [15:0] q;
        recip = (cnt == CNT9) ? RECIP_9 : RECIP_3_6;
        prod  = 33'(sum) * 33'(recip);
        case (cnt)
            CNT2:    q = 16'({sum, 7'b0});
            CNT4:    q = 16'({sum, 6'b0});
            CNT3:    q = prod[29:14];
            CNT6:    q = prod[30:15];
            CNT9:    q = prod[31:16];
            default: q = 16'd0;
        endcase
        return q;
    endfunction

endpackage

### design/box_smooth_3x3_edge_aware.sv
// Top level of the streaming 3x3 edge-aware box smoother with its line store and result queue.
//
// Samples enter in raster order on the sample channel (sample_valid, sample_stall, mode,
// sample); each request is one sample, or a drain item once the last row has been taken.
// Results leave on the result channel (result_valid, result_stall and the result fields),
// one request per smoothed position, lagging the input by one row and one column.
// A request that ends a row gives two results; every other request gives at most one.
// One sample is taken every cycle while sample_stall is low; a row of W samples yields W
// results, so the output keeps pace. Behind a taken sample come the line store read, the
// window shift and the neighbourhood sum, after which the division by a reciprocal writes
// the result queue.
// The result queue holds eight results. The sample channel stalls while seven or more
// results are outstanding, so a stalled receiver backs the stream up without loss.
// The APB port holds image_width at address 0 and image_height at address 4; both are
// clamped to 2..2048 in use and reset to 2048. Write them only while the block is idle.
// Reset clears the position counters, the window and the queue. The line store is not
// cleared: every entry is written in a frame before it is read.
module box_smooth_3x3_edge_aware
    import bs3_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  logic              mode,
    input  logic [7:0]        sample,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [15:0]       smoothed,
    output logic [COL_W-1:0]  out_row,
    output logic [COL_W-1:0]  out_col,
    output logic              frame_end,
    output logic              last
);

    // Configuration registers.
    logic [11:0] width_reg;
    logic [11:0] height_reg;

    // Position of the next sample.
    logic [SIDE_W-1:0] row_count_reg, row_count_next;
    logic [COL_W-1:0]  col_count_reg, col_count_next;

    // Line store: upper byte is the row two above, lower byte the row above.
    logic [15:0] line_mem [MAX_SIDE];
    logic [15:0] rd_reg;

    // Stage 0: request taken, line store read in flight.
    logic              s0_valid_reg;
    logic [SIDE_W-1:0] s0_row_reg;
    logic [COL_W-1:0]  s0_col_reg;
    logic              s0_flush_reg;
    logic              s0_row_end_reg;
    logic              s0_first_reg;
    logic              s0_second_reg;
    logic [7:0]        s0_bottom_reg;

    // Stage 1: window shifted.
    logic              s1_valid_reg;
    logic [SIDE_W-1:0] s1_row_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic              s1_flush_reg;
    logic              s1_row_end_reg;
    logic              s1_first_reg;
    logic              s1_second_reg;
    logic [7:0]        win_reg [3][3];

    // Stage 2: neighbourhood sums.
    logic              s2_valid_reg;
    logic [11:0]       s2_sum_a_reg;
    logic [11:0]       s2_sum_b_reg;
    cnt_t              s2_cnt_a_reg;
    cnt_t              s2_cnt_b_reg;
    logic [COL_W-1:0]  s2_row_reg;
    logic [COL_W-1:0]  s2_col_a_reg;
    logic [COL_W-1:0]  s2_col_b_reg;
    logic              s2_last_a_reg;
    logic              s2_fend_reg;
    logic              s2_first_reg;
    logic              s2_second_reg;

    // Result queue and the count of results promised but not yet delivered.
    result_t               fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] head_reg, head_next;
    logic [FIFO_PTR_W-1:0] tail_reg, tail_next;
    logic [FIFO_CNT_W-1:0] fifo_count_reg, fifo_count_next;
    logic [FIFO_CNT_W-1:0] reserved_reg, reserved_next;

    logic              cfg_write;
    logic [SIDE_W-1:0] width_use;
    logic [SIDE_W-1:0] height_use;
    logic              accept;
    logic              flush;
    logic              row_end;
    logic              effective;
    logic              first_res;
    logic              second_res;
    logic [1:0]        accept_n;
    logic              pop;
    logic              push_a;
    logic              push_b;
    logic              top_ok;
    logic              bot_ok;
    logic [9:0]        col_sum [3];
    logic [11:0]       sum_a;
    logic [11:0]       sum_b;
    result_t           res_a;
    result_t           res_b;
    result_t           head_res;

    // ---------------------------------------------------------------- configuration
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_comb
    begin
        unique case (paddr[2])
            REG_IMAGE_WIDTH:  prdata = {20'd0, width_reg};
            REG_IMAGE_HEIGHT: prdata = {20'd0, height_reg};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIDE_RESET;
            height_reg <= SIDE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[11:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[11:0];
                default:          ;
            endcase
        end
    end

    // ---------------------------------------------------------------- request intake
    // The sample channel stalls once a further row-ending request could overflow
    // the result queue.
    assign sample_stall = reserved_reg > FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign accept       = sample_valid & ~sample_stall;

    assign width_use  = clamp_side(width_reg);
    assign height_use = clamp_side(height_reg);

    // Once every row has been taken, the block is in the flush row, where each
    // request acts as a drain item. A drain item ahead of that is simply dropped.
    assign flush      = row_count_reg >= height_use;
    assign row_end    = {1'b0, col_count_reg} >= (width_use - SIDE_W'(1));
    assign effective  = accept & ~(mode & ~flush);
    assign first_res  = (row_count_reg != '0) & (col_count_reg != '0);
    assign second_res = (row_count_reg != '0) & row_end;
    assign accept_n   = effective ? ({1'b0, first_res} + {1'b0, second_res}) : 2'd0;

    always_comb
    begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (effective)
        begin
            if (row_end)
            begin
                col_count_next = '0;
                row_count_next = flush ? '0 : row_count_reg + SIDE_W'(1);
            end
            else
            begin
                col_count_next = col_count_reg + COL_W'(1);
            end
        end
    end

    // ---------------------------------------------------------------- line store
    // A column is read when its sample is taken and written in the next cycle with the
    // shifted pair; the same column is next read at least a row later.
    always_ff @(posedge clk)
    begin
        rd_reg <= line_mem[col_count_reg];
        if (s0_valid_reg && !s0_flush_reg)
        begin
            line_mem[s0_col_reg] <= {rd_reg[7:0], s0_bottom_reg};
        end
    end

    // ---------------------------------------------------------------- stage payloads
    always_ff @(posedge clk)
    begin
        s0_row_reg     <= row_count_reg;
        s0_col_reg     <= col_count_reg;
        s0_flush_reg   <= flush;
        s0_row_end_reg <= row_end;
        s0_first_reg   <= first_res;
        s0_second_reg  <= second_res;
        s0_bottom_reg  <= flush ? 8'd0 : sample;

        s1_row_reg     <= s0_row_reg;
        s1_col_reg     <= s0_col_reg;
        s1_flush_reg   <= s0_flush_reg;
        s1_row_end_reg <= s0_row_end_reg;
        s1_first_reg   <= s0_first_reg;
        s1_second_reg  <= s0_second_reg;

        s2_sum_a_reg  <= sum_a;
        s2_sum_b_reg  <= sum_b;
        s2_cnt_a_reg  <= count_code(top_ok, bot_ok, s1_col_reg >= COL_W'(2));
        s2_cnt_b_reg  <= count_code(top_ok, bot_ok, 1'b0);
        s2_row_reg    <= COL_W'(s1_row_reg - SIDE_W'(1));
        s2_col_a_reg  <= s1_col_reg - COL_W'(1);
        s2_col_b_reg  <= s1_col_reg;
        s2_last_a_reg <= ~s1_row_end_reg;
        s2_fend_reg   <= s1_flush_reg;
        s2_first_reg  <= s1_first_reg;
        s2_second_reg <= s1_second_reg;

        if (push_a)
        begin
            fifo_reg[tail_reg] <= res_a;
        end
        if (push_b)
        begin
            fifo_reg[tail_reg + FIFO_PTR_W'(push_a)] <= res_b;
        end
    end

    // ---------------------------------------------------------------- neighbourhood sums
    // The top row is left out on the first image row and the bottom row in the flush
    // row. The left column counts only when the position is not on the left edge.
    assign top_ok = s1_row_reg >= SIDE_W'(2);
    assign bot_ok = ~s1_flush_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            col_sum[j] = (top_ok ? 10'(win_reg[0][j]) : 10'd0) + 10'(win_reg[1][j])
                       + (bot_ok ? 10'(win_reg[2][j]) : 10'd0);
        end
        sum_b = 12'(col_sum[1]) + 12'(col_sum[2]);
        sum_a = sum_b + ((s1_col_reg >= COL_W'(2)) ? 12'(col_sum[0]) : 12'd0);
    end

    // ---------------------------------------------------------------- division and queue
    // The first result is the position one column back; a row-ending request adds the
    // position at its own column, which never sees a right-hand neighbour.
    assign push_a = s2_valid_reg & s2_first_reg;
    assign push_b = s2_valid_reg & s2_second_reg;

    assign res_a = '{smoothed:  mean_q88(s2_sum_a_reg, s2_cnt_a_reg),
                     row:       s2_row_reg,
                     col:       s2_col_a_reg,
                     frame_end: 1'b0,
                     last:      s2_last_a_reg};
    assign res_b = '{smoothed:  mean_q88(s2_sum_b_reg, s2_cnt_b_reg),
                     row:       s2_row_reg,
                     col:       s2_col_b_reg,
                     frame_end: s2_fend_reg,
                     last:      1'b1};

    assign result_valid = fifo_count_reg != '0;
    assign pop          = result_valid & ~result_stall;
    assign head_res     = fifo_reg[head_reg];
    assign smoothed     = head_res.smoothed;
    assign out_row      = head_res.row;
    assign out_col      = head_res.col;
    assign frame_end    = head_res.frame_end;
    assign last         = head_res.last;

    always_comb
    begin
        head_next       = head_reg + FIFO_PTR_W'(pop);
        tail_next       = tail_reg + FIFO_PTR_W'(push_a) + FIFO_PTR_W'(push_b);
        fifo_count_next = fifo_count_reg + FIFO_CNT_W'(push_a) + FIFO_CNT_W'(push_b)
                        - FIFO_CNT_W'(pop);
        reserved_next   = reserved_reg + FIFO_CNT_W'(accept_n) - FIFO_CNT_W'(pop);
    end

    // ---------------------------------------------------------------- control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg  <= '0;
            col_count_reg  <= '0;
            s0_valid_reg   <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            fifo_count_reg <= '0;
            reserved_reg   <= '0;
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[k][j] <= 8'd0;
                end
            end
        end
        else
        begin
            row_count_reg  <= row_count_next;
            col_count_reg  <= col_count_next;
            s0_valid_reg   <= effective;
            s1_valid_reg   <= s0_valid_reg;
            s2_valid_reg   <= s1_valid_reg;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            fifo_count_reg <= fifo_count_next;
            reserved_reg   <= reserved_next;
            if (s0_valid_reg)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[k][0] <= win_reg[k][1];
                    win_reg[k][1] <= win_reg[k][2];
                end
                win_reg[0][2] <= rd_reg[15:8];
                win_reg[1][2] <= rd_reg[7:0];
                win_reg[2][2] <= s0_bottom_reg;
            end
        end
    end

endmodule
